// File: rtl/core/dspo_pkg.sv
package dspo_pkg;

  localparam int COUNT_BITS_DEF   = 32;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int ATAN_ENTRIES = 24;
  localparam int IDX_W        = 5;
  // cordic datapath widths
  localparam int CW = 40;
  localparam int ZW = 34;
  // distance and sum width, 2^-24 mm
  localparam int DW = 36;

  localparam logic [20:0] STEP_Q24     = 21'd1844751;
  localparam logic [31:0] TRACK_Q24    = 32'd1303589683;
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

  localparam logic signed [23:0] SPEED_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SPEED_MIN = -24'sh800000;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  localparam logic [2:0] REG_LEFT_PERIOD   = 3'd0;
  localparam logic [2:0] REG_RIGHT_PERIOD  = 3'd1;
  localparam logic [2:0] REG_LEFT_ENABLE   = 3'd2;
  localparam logic [2:0] REG_RIGHT_ENABLE  = 3'd3;
  localparam logic [2:0] REG_LEFT_REVERSE  = 3'd4;
  localparam logic [2:0] REG_RIGHT_REVERSE = 3'd5;
  localparam logic [2:0] REG_WINDOW_TICKS  = 3'd6;

  typedef struct packed {
    logic apply;
    logic prep;
    logic vec_start;
    logic vec_fin;
    logic mul_lo;
    logic mul_hi;
    logic rot_start;
    logic rot_fin;
    logic out_load;
  } dspo_cmd_t;

  typedef struct packed {
    logic win_close;
    logic cordic_busy;
  } dspo_status_t;

  function automatic logic [31:0] atan_q32(input logic [IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10680862;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/dual_stepper_pulse_odometry.sv
// channel   | dir | handshake          | contents
// s_        | in  | s_tvalid/s_tready  | tuser op, tdata load_x, load_y
// m_        | out | m_tvalid/m_tready  | step levels, counts, speed, position, heading
// cfg_      | in  | cfg_we             | register index, write data
//
// a tick that does not close a window, and ops 1 to 3, go from the idle state through
// the hold state, which loads the output register when it is free; input is taken
// again back in the idle state
// a window close also passes the prep, vectoring, multiply and rotation states,
// running the single shared iterative cordic unit twice
// one word in work at a time; a finished word waits in the output register
// rst is synchronous and active high; no clearing pass
module dual_stepper_pulse_odometry import dspo_pkg::*; #(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,  // load_x, load_y
  input  logic [1:0]   s_tuser,  // op
  output logic         m_tvalid,
  input  logic         m_tready,
  // left_step, right_step, left_count, right_count, speed, pos_x, pos_y,
  // heading, quadrant, zero pad
  output logic [175:0] m_tdata,
  output logic         m_tuser,  // window_done
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  dspo_cmd_t    cmd;
  dspo_status_t status;

  dspo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dspo_datapath #(
    .COUNT_BITS   (COUNT_BITS),
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .op        (s_tuser),
    .load_x    (s_tdata[31:0]),
    .load_y    (s_tdata[63:32]),
    .out_data  (m_tdata),
    .out_done  (m_tuser)
  );

endmodule

// File: rtl/core/dspo_cordic.sv
module dspo_cordic import dspo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 rot_mode,
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  output logic                 busy,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic signed [ZW-1:0] z
);

  localparam int N = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  logic [IDX_W-1:0]     cnt;
  logic                 mode;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] a;
  logic                 d_pos;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign a  = ZW'(atan_q32(cnt));
  // rotate toward z = 0, or toward y = 0 when vectoring
  assign d_pos = mode ? !z[ZW-1] : !(!y[CW-1] && (y != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == IDX_W'(N - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode <= rot_mode;
      x    <= x0;
      y    <= y0;
      z    <= z0;
    end else if (busy) begin
      if (d_pos) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - a;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + a;
      end
    end
  end

endmodule

// File: rtl/core/dspo_datapath.sv
module dspo_datapath import dspo_pkg::*; #(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  dspo_cmd_t           cmd,
  output dspo_status_t        status,
  input  logic [1:0]          op,
  input  logic [31:0]         load_x,
  input  logic [31:0]         load_y,
  output logic [175:0]        out_data,
  output logic                out_done
);

  localparam int AB = ANGLE_BITS;

  logic [15:0] left_period, right_period;
  logic        left_enable, right_enable, left_reverse, right_reverse;
  logic [9:0]  window_ticks;

  logic [15:0]           left_ticks, right_ticks;
  logic                  left_level, right_level;
  logic [COUNT_BITS-1:0] left_signed, right_signed;
  logic [10:0]           left_window_edges, right_window_edges;
  logic [9:0]            window_count;
  logic [31:0]           x_acc, y_acc;
  logic [AB-1:0]         turned_angle;
  logic signed [23:0]    speed_reg;
  logic [1:0]            quadrant_reg;
  logic                  done;

  logic signed [DW-1:0] dl, dr, sum;
  logic                 ydz;
  logic signed [26:0]   m;
  logic signed [63:0]   macc;
  logic [1:0]           q;
  logic signed [31:0]   ru;

  logic                 l_step, r_step;
  logic [9:0]           wc_inc;
  logic signed [DW-1:0] dl_raw, dr_raw;
  logic signed [43:0]   s50;
  logic signed [27:0]   sp;
  logic signed [ZW-1:0] zsum;
  logic signed [ZW-1:0] zrnd;
  logic [AB-1:0]        hd, hd_new;
  logic [31:0]          a32;
  logic [1:0]           q_c;
  logic signed [CW-1:0] mg;
  logic signed [CW-1:0] rx0, ry0;
  logic signed [CW-1:0] xr, yr;
  logic [2:0]           t3;
  logic [63:0]          lc_w, rc_w;
  logic [31:0]          hd_w;

  logic                 c_busy;
  logic signed [CW-1:0] c_x, c_y;
  logic signed [ZW-1:0] c_z;

  assign l_step = left_enable && (left_period <= left_ticks);
  assign r_step = right_enable && (right_period <= right_ticks);
  assign wc_inc = window_count + 10'd1;

  assign status.win_close   = (op == OP_TICK) && (wc_inc == window_ticks);
  assign status.cordic_busy = c_busy;

  assign dl_raw = DW'(left_window_edges * STEP_Q24);
  assign dr_raw = DW'(right_window_edges * STEP_Q24);

  assign s50 = (44'(sum) <<< 5) + (44'(sum) <<< 4) + (44'(sum) <<< 1) + 44'sd32768;
  assign sp  = 28'(s50 >>> 16);

  assign zsum = c_z + (ZW'(1) <<< (31 - AB));
  assign zrnd = zsum >>> (32 - AB);

  assign hd     = turned_angle + (AB'(1) << (AB - 2));
  assign hd_new = turned_angle + (ydz ? '0 : zrnd[AB-1:0]);
  assign a32    = 32'(hd) << (32 - AB);
  assign q_c    = 2'((a32 + 32'h2000_0000) >> 30);
  assign t3     = hd_new[AB-1:AB-3];

  assign mg = CW'(macc >>> 32);
  always_comb begin
    case (q)
      2'd0: begin rx0 = mg; ry0 = '0; end
      2'd1: begin rx0 = '0; ry0 = mg; end
      2'd2: begin rx0 = -mg; ry0 = '0; end
      default: begin rx0 = '0; ry0 = -mg; end
    endcase
  end

  assign xr = (c_x + CW'(128)) >>> 8;
  assign yr = (c_y + CW'(128)) >>> 8;

  dspo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.vec_start || cmd.rot_start),
    .rot_mode (cmd.rot_start),
    .x0       (cmd.rot_start ? rx0 : CW'(TRACK_Q24)),
    .y0       (cmd.rot_start ? ry0 : CW'(dr - dl)),
    .z0       (cmd.rot_start ? ZW'(ru) : '0),
    .busy     (c_busy),
    .x        (c_x),
    .y        (c_y),
    .z        (c_z)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      left_period   <= '0;
      right_period  <= '0;
      left_enable   <= 1'b0;
      right_enable  <= 1'b0;
      left_reverse  <= 1'b0;
      right_reverse <= 1'b0;
      window_ticks  <= 10'd400;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_PERIOD:   left_period   <= cfg_data;
        REG_RIGHT_PERIOD:  right_period  <= cfg_data;
        REG_LEFT_ENABLE:   left_enable   <= cfg_data[0];
        REG_RIGHT_ENABLE:  right_enable  <= cfg_data[0];
        REG_LEFT_REVERSE:  left_reverse  <= cfg_data[0];
        REG_RIGHT_REVERSE: right_reverse <= cfg_data[0];
        REG_WINDOW_TICKS:  window_ticks  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // odometry state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_ticks         <= '0;
      right_ticks        <= '0;
      left_level         <= 1'b0;
      right_level        <= 1'b0;
      left_signed        <= '0;
      right_signed       <= '0;
      left_window_edges  <= '0;
      right_window_edges <= '0;
      window_count       <= '0;
      x_acc              <= '0;
      y_acc              <= '0;
      turned_angle       <= '0;
      speed_reg          <= '0;
      quadrant_reg       <= 2'd3;
      done               <= 1'b0;
    end else begin
      if (cmd.apply) begin
        done <= status.win_close;
        case (op)
          OP_TICK: begin
            if (l_step) begin
              left_level        <= ~left_level;
              left_ticks        <= '0;
              left_window_edges <= left_window_edges + 11'd1;
              left_signed       <= left_reverse ? left_signed - 1'b1 : left_signed + 1'b1;
            end else begin
              left_ticks <= left_ticks + 16'd1;
            end
            if (r_step) begin
              right_level        <= ~right_level;
              right_ticks        <= '0;
              right_window_edges <= right_window_edges + 11'd1;
              right_signed       <= right_reverse ? right_signed - 1'b1
                                                  : right_signed + 1'b1;
            end else begin
              right_ticks <= right_ticks + 16'd1;
            end
            window_count <= status.win_close ? '0 : wc_inc;
          end
          OP_CLEAR: begin
            left_signed  <= '0;
            right_signed <= '0;
          end
          OP_LOAD: begin
            x_acc <= load_x;
            y_acc <= load_y;
          end
          default: ;
        endcase
      end
      if (cmd.prep) begin
        left_window_edges  <= '0;
        right_window_edges <= '0;
      end
      if (cmd.vec_fin) begin
        turned_angle <= hd_new;
        if (sp > 28'(SPEED_MAX)) begin
          speed_reg <= SPEED_MAX;
        end else if (sp < 28'(SPEED_MIN)) begin
          speed_reg <= SPEED_MIN;
        end else begin
          speed_reg <= 24'(sp);
        end
        case (t3)
          3'd1, 3'd2: quadrant_reg <= 2'd0;
          3'd3, 3'd4: quadrant_reg <= 2'd1;
          3'd5, 3'd6: quadrant_reg <= 2'd2;
          default:    quadrant_reg <= 2'd3;
        endcase
      end
      if (cmd.rot_fin) begin
        x_acc <= x_acc + xr[31:0];
        y_acc <= y_acc + yr[31:0];
      end
    end
  end

  // window arithmetic
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dl <= left_signed[COUNT_BITS-1] ? -dl_raw : dl_raw;
      dr <= right_signed[COUNT_BITS-1] ? -dr_raw : dr_raw;
    end
    if (cmd.vec_start) begin
      sum <= dl + dr;
      ydz <= (dl == dr);
    end
    if (cmd.vec_fin) begin
      m <= 27'(sum >>> 9);
    end
    if (cmd.mul_lo) begin
      macc <= 64'(m * $signed({1'b0, INV_GAIN_Q32[15:0]})) + 64'sh8000_0000;
      q    <= q_c;
      ru   <= $signed(a32 - {q_c, 30'b0});
    end
    if (cmd.mul_hi) begin
      macc <= macc + (64'(m * $signed({1'b0, INV_GAIN_Q32[31:16]})) <<< 16);
    end
  end

  assign lc_w = 64'(left_signed);
  assign rc_w = 64'(right_signed);
  assign hd_w = 32'(hd);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {4'b0, quadrant_reg, hd_w[15:0], y_acc, x_acc, speed_reg,
                   rc_w[31:0], lc_w[31:0], right_level, left_level};
      out_done <= done;
    end
  end

endmodule

// File: rtl/core/dspo_ctrl.sv
module dspo_ctrl import dspo_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  dspo_status_t status,
  output dspo_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_VLOAD = 4'd2;
  localparam logic [3:0] S_VEC   = 4'd3;
  localparam logic [3:0] S_VFIN  = 4'd4;
  localparam logic [3:0] S_MUL0  = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_RLOAD = 4'd7;
  localparam logic [3:0] S_ROT   = 4'd8;
  localparam logic [3:0] S_RFIN  = 4'd9;
  localparam logic [3:0] S_HOLD  = 4'd10;

  logic [3:0] state, state_next;
  logic       accept;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.apply  = 1'b1;
          state_next = status.win_close ? S_PREP : S_HOLD;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_VLOAD;
      end
      S_VLOAD: begin
        cmd.vec_start = 1'b1;
        state_next    = S_VEC;
      end
      S_VEC: begin
        if (!status.cordic_busy) begin
          state_next = S_VFIN;
        end
      end
      S_VFIN: begin
        cmd.vec_fin = 1'b1;
        state_next  = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_next = S_RLOAD;
      end
      S_RLOAD: begin
        cmd.rot_start = 1'b1;
        state_next    = S_ROT;
      end
      S_ROT: begin
        if (!status.cordic_busy) begin
          state_next = S_RFIN;
        end
      end
      S_RFIN: begin
        cmd.rot_fin = 1'b1;
        state_next  = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_close_prep: assert property (@(posedge clk) disable iff (rst)
    accept && status.win_close |=> state == S_PREP)
    else $error("window close did not start the odometry update");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output word overwritten while waiting");

  a_vfin_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_VFIN || state == S_RFIN) |-> !status.cordic_busy)
    else $error("cordic result used while still iterating");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded word not presented");

endmodule

// File: dv/dual_stepper_pulse_odometry_test.sv
module dual_stepper_pulse_odometry_test;
  import dspo_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [3:0] pad;
    logic [1:0] quadrant;
    logic [15:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [23:0] speed;
    logic [31:0] right_count;
    logic [31:0] left_count;
    logic right_step;
    logic left_step;
  } odo_word_t;

  typedef struct packed {
    odo_word_t w;
    logic done;
  } odo_result_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
  logic [63:0] s_tdata;
  logic [1:0] s_tuser;
  logic [175:0] m_tdata;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  dual_stepper_pulse_odometry dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // own arctangent table, 2^-32 turn
  localparam longint ARCTAN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  // predicted block state
  logic [15:0] l_period, r_period, l_ticks, r_ticks, angle_turned;
  logic l_en, r_en, l_rev, r_rev, l_lvl, r_lvl;
  logic [9:0] win_len, win_pos;
  logic [10:0] l_edges, r_edges;
  logic [31:0] l_cnt, r_cnt, x_pos, y_pos;
  logic [23:0] speed_now;
  logic [1:0] quad_now;

  odo_result_t odo_expected[$];
  int mismatches, words_seen, windows_seen, items_sent, idle_cycles;
  int rx_wait, hold_left;
  bit hold_req;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic void step_wheel(input logic [15:0] period, input logic en,
                                     input logic rev,
                                     inout logic [15:0] ticks, inout logic lvl,
                                     inout logic [31:0] cnt, inout logic [10:0] edges);
    if (en && period <= ticks) begin
      lvl = ~lvl;
      ticks = 0;
      edges = edges + 1;
      cnt = cnt + (rev ? 32'hFFFF_FFFF : 32'd1);
    end else begin
      ticks = ticks + 1;
    end
  endfunction

  function automatic void close_window_odometry();
    longint dl, dr, sum, sp, x, y, z, m, t;
    logic [31:0] a32, ru;
    logic [1:0] q;
    dl = longint'(l_edges) * 1844751;
    dr = longint'(r_edges) * 1844751;
    if (l_cnt[31]) dl = -dl;
    if (r_cnt[31]) dr = -dr;
    l_edges = 0;
    r_edges = 0;
    sum = dl + dr;
    sp = (sum * 50 + 32768) >>> 16;
    if (sp > 8388607) sp = 8388607;
    if (sp < -8388608) sp = -8388608;
    speed_now = sp[23:0];
    x = 1303589683;
    y = dr - dl;
    z = 0;
    if (y != 0) begin
      for (int i = 0; i < 16; i++) begin
        t = x;
        if (y > 0) begin
          x += y >>> i; y -= t >>> i; z += ARCTAN[i];
        end else begin
          x -= y >>> i; y += t >>> i; z -= ARCTAN[i];
        end
      end
      z = (z + (64'sd1 <<< 15)) >>> 16;
    end
    angle_turned = angle_turned + z[15:0];
    if (angle_turned >= 16'h2000 && angle_turned < 16'h6000) quad_now = 0;
    else if (angle_turned >= 16'h6000 && angle_turned < 16'hA000) quad_now = 1;
    else if (angle_turned >= 16'hA000 && angle_turned < 16'hE000) quad_now = 2;
    else quad_now = 3;
    a32 = {16'h4000 + angle_turned, 16'h0};
    q = 2'((a32 + 32'h2000_0000) >> 30);
    ru = a32 - {q, 30'h0};
    z = longint'($signed(ru));
    m = sum >>> 9;
    m = (m * 64'sd2608131496 + (64'sd1 <<< 31)) >>> 32;
    case (q)
      2'd0: begin x = m; y = 0; end
      2'd1: begin x = 0; y = m; end
      2'd2: begin x = -m; y = 0; end
      default: begin x = 0; y = -m; end
    endcase
    for (int i = 0; i < 16; i++) begin
      t = x;
      if (z >= 0) begin
        x -= y >>> i; y += t >>> i; z -= ARCTAN[i];
      end else begin
        x += y >>> i; y -= t >>> i; z += ARCTAN[i];
      end
    end
    t = (x + 128) >>> 8;
    x_pos = x_pos + t[31:0];
    t = (y + 128) >>> 8;
    y_pos = y_pos + t[31:0];
  endfunction

  function automatic odo_result_t predict_odometry(input logic [1:0] op,
                                                   input logic [31:0] lx, input logic [31:0] ly);
    odo_result_t r;
    r.done = 0;
    if (op == OP_TICK) begin
      step_wheel(l_period, l_en, l_rev, l_ticks, l_lvl, l_cnt, l_edges);
      step_wheel(r_period, r_en, r_rev, r_ticks, r_lvl, r_cnt, r_edges);
      win_pos = win_pos + 1;
      if (win_pos == win_len) begin
        close_window_odometry();
        win_pos = 0;
        r.done = 1;
      end
    end else if (op == OP_CLEAR) begin
      l_cnt = 0;
      r_cnt = 0;
    end else if (op == OP_LOAD) begin
      x_pos = lx;
      y_pos = ly;
    end
    r.w.pad = 0;
    r.w.quadrant = quad_now;
    r.w.heading = 16'h4000 + angle_turned;
    r.w.pos_y = y_pos;
    r.w.pos_x = x_pos;
    r.w.speed = speed_now;
    r.w.right_count = r_cnt;
    r.w.left_count = l_cnt;
    r.w.right_step = r_lvl;
    r.w.left_step = l_lvl;
    return r;
  endfunction

  task automatic reset_model();
    l_period = 0; r_period = 0; l_en = 0; r_en = 0; l_rev = 0; r_rev = 0;
    win_len = 400; win_pos = 0; l_ticks = 0; r_ticks = 0; l_lvl = 0; r_lvl = 0;
    l_cnt = 0; r_cnt = 0; l_edges = 0; r_edges = 0; x_pos = 0; y_pos = 0;
    angle_turned = 0; speed_now = 0; quad_now = 3;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LEFT_PERIOD: l_period = val;
      REG_RIGHT_PERIOD: r_period = val;
      REG_LEFT_ENABLE: l_en = val[0];
      REG_RIGHT_ENABLE: r_en = val[0];
      REG_LEFT_REVERSE: l_rev = val[0];
      REG_RIGHT_REVERSE: r_rev = val[0];
      REG_WINDOW_TICKS: win_len = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic setup(input int lp, input int rp, input int le, input int re,
                       input int lr, input int rr, input int wt);
    write_reg(REG_LEFT_PERIOD, 16'(lp));
    write_reg(REG_RIGHT_PERIOD, 16'(rp));
    write_reg(REG_LEFT_ENABLE, 16'(le));
    write_reg(REG_RIGHT_ENABLE, 16'(re));
    write_reg(REG_LEFT_REVERSE, 16'(lr));
    write_reg(REG_RIGHT_REVERSE, 16'(rr));
    write_reg(REG_WINDOW_TICKS, 16'(wt));
  endtask

  // enter at any time, leave just after the accepting edge
  task automatic send_word(input logic [1:0] op, input logic [31:0] lx, input logic [31:0] ly);
    int gap;
    gap = $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {ly, lx};
    do @(posedge clk); while (!s_tready);
    odo_expected.insert(odo_expected.size(), predict_odometry(op, lx, ly));
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 0;
    while (odo_expected.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic send_random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) send_word(OP_TICK, $urandom, $urandom);
    else if (pick < 87) send_word(OP_CLEAR, $urandom, $urandom);
    else if (pick < 94) send_word(OP_LOAD, $urandom, $urandom);
    else send_word(OP_UNUSED, $urandom, $urandom);
  endtask

  task automatic test_directed();
    send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OP_CLEAR, 0, 0);
    drain();
    // both wheels every tick, straight line
    setup(0, 0, 1, 1, 0, 0, 1);
    repeat (4) send_word(OP_TICK, 0, 0);
    drain();
    // left reversed, turning
    setup(0, 1, 1, 1, 1, 0, 2);
    repeat (6) send_word(OP_TICK, 0, 0);
    send_word(OP_CLEAR, 0, 0);
    drain();
    // slowest period, right only
    setup(65535, 0, 1, 1, 0, 1, 3);
    repeat (6) send_word(OP_TICK, 0, 0);
    drain();
  endtask

  task automatic test_window_extremes();
    // zero window does not close early, then the longest window
    setup(0, 2, 1, 1, 0, 0, 0);
    repeat (40) send_word(OP_TICK, 0, 0);
    drain();
    setup(1, 0, 1, 1, 1, 1, 1023);
    repeat (40) send_word(OP_TICK, 0, 0);
    drain();
  endtask

  task automatic test_random();
    int lp, rp, wt;
    for (int ph = 0; ph < 12; ph++) begin
      lp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
      rp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
      wt = $urandom_range(1, 12);
      setup(lp, rp, $urandom_range(0, 1), $urandom_range(0, 1),
            $urandom_range(0, 1), $urandom_range(0, 1), wt);
      repeat (45) send_random_word();
      drain();
    end
  endtask

  task automatic test_backpressure();
    setup(0, 3, 1, 1, 0, 1, 2);
    hold_req = 1;
    repeat (30) send_random_word();
    drain();
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (rst) begin
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    odo_result_t act, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      words_seen++;
      rx_wait = $urandom_range(0, 3);
      act.w = m_tdata;
      act.done = m_tuser;
      if (odo_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_tdata);
      end else begin
        exp_r = odo_expected.pop_front();
        if (exp_r.done) windows_seen++;
        if (act.w.left_step !== exp_r.w.left_step || act.w.right_step !== exp_r.w.right_step ||
            act.w.left_count !== exp_r.w.left_count ||
            act.w.right_count !== exp_r.w.right_count || act.w.speed !== exp_r.w.speed ||
            act.w.pos_x !== exp_r.w.pos_x || act.w.pos_y !== exp_r.w.pos_y ||
            act.w.heading !== exp_r.w.heading || act.w.quadrant !== exp_r.w.quadrant ||
            act.done !== exp_r.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch word %0d: exp st %b%b cnt %h %h spd %h pos %h %h hd %h q %0d d %b\n  got st %b%b cnt %h %h spd %h pos %h %h hd %h q %0d d %b",
                     words_seen, exp_r.w.left_step, exp_r.w.right_step, exp_r.w.left_count,
                     exp_r.w.right_count, exp_r.w.speed, exp_r.w.pos_x, exp_r.w.pos_y,
                     exp_r.w.heading, exp_r.w.quadrant, exp_r.done,
                     act.w.left_step, act.w.right_step, act.w.left_count, act.w.right_count,
                     act.w.speed, act.w.pos_x, act.w.pos_y, act.w.heading, act.w.quadrant,
                     act.done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    mismatches = 0; words_seen = 0; windows_seen = 0; items_sent = 0;
    idle_cycles = 0; rx_wait = 0; hold_left = 0; hold_req = 0;
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_random();
    test_backpressure();
    test_window_extremes();
    drain();
    if (odo_expected.size() != 0) mismatches++;
    $display("sent %0d words, checked %0d results, %0d closed windows, %0d mismatches",
             items_sent, words_seen, windows_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
